### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by ascii_can_frame_decoder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### design/acfd_pkg.sv
// ----------------------------------------------------------------------------
// acfd_pkg
// Shared types and constants of the ASCII CAN frame decoder.
// ----------------------------------------------------------------------------
package acfd_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_8     = 8'h38;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_STD_D = 8'h74;  // t
  localparam logic [7:0] CHAR_STD_R = 8'h72;  // r
  localparam logic [7:0] CHAR_EXT_D = 8'h54;  // T
  localparam logic [7:0] CHAR_EXT_R = 8'h52;  // R

  localparam logic [4:0] POS_MAX = 5'd31;

  typedef enum logic [1:0] {
    KIND_NONE = 2'd0,
    KIND_STD  = 2'd1,
    KIND_EXT  = 2'd2
  } kind_t;

  // one classified character
  typedef struct packed {
    logic       is_cr;
    kind_t      kind;    // frame type if this were the first character
    logic       rmt;
    logic       hex_ok;
    logic       len_ok;  // '0'..'8'
    logic [3:0] nib;
  } tok_t;

endpackage

### design/acfd_front.sv
// ----------------------------------------------------------------------------
// acfd_front
// Classifies each received character into a parser token.
// ----------------------------------------------------------------------------
module acfd_front import acfd_pkg::*; (
  input  logic [7:0] rx_byte,
  output tok_t       tok
);

  logic is_dec, is_lc, is_uc;

  always_comb begin
    is_dec = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
    is_lc  = (rx_byte >= CHAR_LA) && (rx_byte <= CHAR_LF);
    is_uc  = (rx_byte >= CHAR_UA) && (rx_byte <= CHAR_UF);

    tok.is_cr  = (rx_byte == CHAR_CR);
    tok.rmt    = (rx_byte == CHAR_STD_R) || (rx_byte == CHAR_EXT_R);
    tok.hex_ok = is_dec || is_lc || is_uc;
    tok.len_ok = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_8);
    // letters: low nibble 1..6 maps to 10..15
    tok.nib    = is_dec ? rx_byte[3:0] : (rx_byte[3:0] + 4'd9);

    if ((rx_byte == CHAR_STD_D) || (rx_byte == CHAR_STD_R)) begin
      tok.kind = KIND_STD;
    end else if ((rx_byte == CHAR_EXT_D) || (rx_byte == CHAR_EXT_R)) begin
      tok.kind = KIND_EXT;
    end else begin
      tok.kind = KIND_NONE;
    end
  end

endmodule

### design/acfd_tokq.sv
// ----------------------------------------------------------------------------
// acfd_tokq
// Small token queue between the classifier and the line parser.
// ----------------------------------------------------------------------------
module acfd_tokq import acfd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst,
  input  logic wr_en,
  input  tok_t wr_tok,
  output logic full,
  input  logic rd_en,
  output logic rd_valid,
  output tok_t rd_tok
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tok_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_tok   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_tok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/acfd_back.sv
// ----------------------------------------------------------------------------
// acfd_back
// Line parser: walks tokens through a frame line and holds the decoded frame.
// ----------------------------------------------------------------------------
module acfd_back import acfd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        tok_valid,
  input  tok_t        tok,
  output logic        tok_pop,
  output logic        empty,
  input  logic        pop,
  output logic [28:0] frame_id,
  output logic        extended,
  output logic        remote,
  output logic [3:0]  byte_count,
  output logic [63:0] payload
);

  logic [4:0]  pos, pos_next;
  kind_t       kind, kind_next;
  logic        rmt, rmt_next;
  logic [28:0] id, id_next;
  logic [3:0]  len, len_next;
  logic [63:0] pay, pay_next;
  logic        bad, bad_next;
  logic        out_valid;

  logic [4:0] idlen, off, len2, need;
  logic [3:0] nidx;
  logic       good;

  // a carriage return waits only while a frame is still held
  assign tok_pop = tok_valid && (!tok.is_cr || !out_valid || pop);
  assign empty   = !out_valid;

  always_comb begin
    idlen = (kind == KIND_EXT) ? 5'd8 : 5'd3;
    off   = pos - idlen - 5'd2;
    len2  = {len, 1'b0};
    need  = idlen + 5'd2 + (rmt ? 5'd0 : len2);
    nidx  = {off[3:1], ~off[0]};  // high nibble of a byte comes first
    good  = (kind != KIND_NONE) && !bad && (pos == need);

    pos_next  = pos;
    kind_next = kind;
    rmt_next  = rmt;
    id_next   = id;
    len_next  = len;
    pay_next  = pay;
    bad_next  = bad;

    if (tok_pop) begin
      if (tok.is_cr) begin
        pos_next  = '0;
        kind_next = KIND_NONE;
        rmt_next  = 1'b0;
        id_next   = '0;
        len_next  = '0;
        pay_next  = '0;
        bad_next  = 1'b0;
      end else begin
        if (pos == 5'd0) begin
          kind_next = tok.kind;
          rmt_next  = tok.rmt;
          bad_next  = (tok.kind == KIND_NONE);
        end else if (!bad && (kind != KIND_NONE)) begin
          if (pos <= idlen) begin
            if (tok.hex_ok) begin
              id_next = {id[24:0], tok.nib};
            end else begin
              bad_next = 1'b1;
            end
          end else if (pos == idlen + 5'd1) begin
            if (tok.len_ok) begin
              len_next = tok.nib;
            end else begin
              bad_next = 1'b1;
            end
          end else if (rmt || (off >= len2) || !tok.hex_ok) begin
            bad_next = 1'b1;
          end else begin
            pay_next[{nidx, 2'b00} +: 4] = pay[{nidx, 2'b00} +: 4] | tok.nib;
          end
        end
        pos_next = (pos == POS_MAX) ? POS_MAX : pos + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      kind      <= KIND_NONE;
      rmt       <= 1'b0;
      id        <= '0;
      len       <= '0;
      pay       <= '0;
      bad       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pos  <= pos_next;
      kind <= kind_next;
      rmt  <= rmt_next;
      id   <= id_next;
      len  <= len_next;
      pay  <= pay_next;
      bad  <= bad_next;
      if (tok_pop && tok.is_cr && good) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_pop && tok.is_cr && good) begin
      frame_id   <= id;
      extended   <= (kind == KIND_EXT);
      remote     <= rmt;
      byte_count <= len;
      payload    <= rmt ? 64'd0 : pay;
    end
  end

endmodule

### design/ascii_can_frame_decoder.sv
// ----------------------------------------------------------------------------
// ascii_can_frame_decoder
// Decodes ASCII CAN frame lines (t/r/T/R, id, length, data, CR) into frames.
// ----------------------------------------------------------------------------
//  channel   | handshake         | payload
//  ----------+-------------------+----------------------------------------------
//  input     | push / full       | rx_byte
//  result    | empty / pop       | frame_id, extended, remote, byte_count, payload
//
//  One character per cycle while full is low; a character is registered in
//  the token queue, and a frame is registered on the result ports from its CR.
//  Synchronous reset empties the token queue and clears the line state.
//  While a frame waits to be popped, ordinary characters flow until a CR heads
//  the token queue; the CR waits, and full rises once DEPTH characters back up.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ascii_can_frame_decoder import acfd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [28:0] frame_id,
  output logic        extended,
  output logic        remote,
  output logic [3:0]  byte_count,
  output logic [63:0] payload
);

  tok_t in_tok, q_tok;
  logic q_valid, q_pop, q_push;

  assign q_push = push && !full;

  acfd_front u_front (
    .rx_byte (rx_byte),
    .tok     (in_tok)
  );

  acfd_tokq #(
    .DEPTH (DEPTH)
  ) u_tokq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_tok   (in_tok),
    .full     (full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_tok   (q_tok)
  );

  acfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .tok_valid  (q_valid),
    .tok        (q_tok),
    .tok_pop    (q_pop),
    .empty      (empty),
    .pop        (pop),
    .frame_id   (frame_id),
    .extended   (extended),
    .remote     (remote),
    .byte_count (byte_count),
    .payload    (payload)
  );

  `ASSERT_IMPLIES(a_full_has_tok, clk, rst, full, q_valid, "queue full but no token")
  `ASSERT_IMPLIES(a_cr_no_overwrite, clk, rst, q_pop && q_tok.is_cr, empty || pop, "frame lost")
  `ASSERT_NEXT(a_rst_clear, clk, 1'b0, rst, empty && !full, "not clear after reset")

endmodule
